[hw/rtl/rhc_pkg.sv]
// Shared constants, types and the division step for the RGB to HSL converter.
`default_nettype none

package rhc_pkg;

  localparam int unsigned DIV_STEPS = 16;

  localparam logic [11:0] HUE_SIXTH      = 12'd3840;
  localparam logic [15:0] HUE_GREEN_BASE = 16'd7680;
  localparam logic [15:0] HUE_BLUE_BASE  = 16'd15360;
  localparam logic [15:0] HUE_FULL       = 16'd23040;
  localparam logic [14:0] HUE_MAX        = 15'd23039;
  localparam logic [15:0] SAT_ONE        = 16'd32768;
  localparam logic [8:0]  LIGHT_FULL     = 9'd510;

  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } rhc_sector_e;

  // Channel compare results, one register stage ahead of the dividers.
  typedef struct packed {
    logic [7:0]  delta;
    logic [7:0]  adiff;
    logic        neg;
    rhc_sector_e sector;
    logic [7:0]  den;
    logic [8:0]  sum;
    logic        grey;
    logic        sat_zero;
  } rhc_prep_t;

  // Partial remainder and shifting dividend/quotient word of one divider.
  typedef struct packed {
    logic [7:0]  rem;
    logic [15:0] dq;
  } rhc_quo_t;

  typedef struct packed {
    rhc_quo_t    hue_q;
    rhc_quo_t    sat_q;
    logic [7:0]  delta;
    logic [7:0]  den;
    logic [8:0]  sum;
    rhc_sector_e sector;
    logic        neg;
    logic        grey;
    logic        sat_zero;
  } rhc_div_t;

  // One restoring division step: remainder stays below the divisor.
  function automatic rhc_quo_t rhc_div_step(input rhc_quo_t cur, input logic [7:0] dvsr);
    logic [8:0] t;
    rhc_quo_t   nxt;
    t = {cur.rem, cur.dq[15]};
    if (t >= {1'b0, dvsr}) begin
      nxt.rem = 8'(t - {1'b0, dvsr});
      nxt.dq  = {cur.dq[14:0], 1'b1};
    end else begin
      nxt.rem = t[7:0];
      nxt.dq  = {cur.dq[14:0], 1'b0};
    end
    return nxt;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/rhc_if.sv]
// Handshake channels for the RGB pixel input and the HSL result output.
`default_nettype none

interface rhc_pixel_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink (input valid, input red, input green, input blue, output ready);
  modport monitor (input valid, input red, input green, input blue, input ready);
endinterface

interface rhc_hsl_if;
  logic        valid;
  logic        ready;
  logic [14:0] hue;
  logic [15:0] saturation;
  logic [8:0]  lightness;

  modport source (output valid, output hue, output saturation, output lightness, input ready);
  modport sink (input valid, input hue, input saturation, input lightness, output ready);
  modport monitor (input valid, input hue, input saturation, input lightness, input ready);
endinterface

`default_nettype wire

[hw/rtl/rgb_to_hsl_convert_core.sv]
// RGB to HSL converter: compare stage, two 16-step pipelined dividers, result register.
//
// pix_i carries one 8-bit RGB pixel per item; hsl_o returns hue (1/64 degree),
// saturation (32768 = 1.0) and lightness (max + min) for each pixel, in order.
// Throughput is one item per clock while hsl_o is not stalled. Each accepted
// item passes through the stages in order: one stage finds max, min and the
// hue sector, one stage forms the dividends, sixteen stages each resolve one
// quotient bit of the hue and saturation divisions side by side, and the last
// stage adds the sector base and drives the output register.
// All stages advance together while the output register is empty or being
// taken; when the receiver holds ready low with a result waiting, the whole
// pipeline and pix_i.ready freeze, so nothing is dropped or repeated.
// Bubbles travel as cleared valid bits.
// Reset (rst_ni low, asynchronous) clears every valid bit; items are accepted
// from the first clock edge after reset is released. There is no configuration.
`default_nettype none

module rgb_to_hsl_convert_core
  import rhc_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  rhc_pixel_if.sink  pix_i,
  rhc_hsl_if.source  hsl_o
);

  logic advance;

  // Compare stage
  logic [7:0] mx, mn, da, db;
  logic [8:0] diff9, inv9, den9;
  rhc_prep_t  prep_d, prep_q;
  logic       prep_v_q;

  // Divider stages
  rhc_div_t           dv_q [DIV_STEPS+1];
  rhc_div_t           dv_n [DIV_STEPS];
  logic [DIV_STEPS:0] dv_v_q;
  rhc_div_t           dv0_d;
  logic [19:0]        hue_dvd;

  // Result stage
  rhc_div_t    last;
  logic [15:0] hue_s, hue_w;
  logic [14:0] hue_d, hue_q;
  logic [15:0] sat_d, sat_q;
  logic [8:0]  light_q;
  logic        out_v_q;

  assign advance     = !out_v_q || hsl_o.ready;
  assign pix_i.ready = advance;

  always_comb begin
    mx = (pix_i.red > pix_i.green) ? pix_i.red : pix_i.green;
    mn = (pix_i.red < pix_i.green) ? pix_i.red : pix_i.green;
    if (pix_i.blue > mx) mx = pix_i.blue;
    if (pix_i.blue < mn) mn = pix_i.blue;

    // First channel equal to max picks the sector
    if (pix_i.red == mx) begin
      prep_d.sector = SEC_RED;
      da = pix_i.green;
      db = pix_i.blue;
    end else if (pix_i.green == mx) begin
      prep_d.sector = SEC_GREEN;
      da = pix_i.blue;
      db = pix_i.red;
    end else begin
      prep_d.sector = SEC_BLUE;
      da = pix_i.red;
      db = pix_i.green;
    end

    diff9        = {1'b0, da} - {1'b0, db};
    prep_d.neg   = diff9[8];
    prep_d.adiff = diff9[8] ? (db - da) : (da - db);
    prep_d.delta = mx - mn;
    prep_d.sum   = {1'b0, mx} + {1'b0, mn};
    inv9         = LIGHT_FULL - prep_d.sum;
    den9         = (prep_d.sum < inv9) ? prep_d.sum : inv9;
    prep_d.den   = den9[7:0];
    prep_d.grey  = (mx == mn);
    // Black and white both give a zero denominator
    prep_d.sat_zero = (den9 == 9'd0);
  end

  always_ff @(posedge clk_i) begin
    if (advance) prep_q <= prep_d;
  end

  // Dividends: 3840*|diff| for hue, delta*32768 for saturation; the top bits
  // seed the remainder and are below the divisor whenever that divisor is nonzero.
  always_comb begin
    hue_dvd = ({12'd0, prep_q.adiff} << 12) - ({12'd0, prep_q.adiff} << 8);
    dv0_d.hue_q.rem = {4'd0, hue_dvd[19:16]};
    dv0_d.hue_q.dq  = hue_dvd[15:0];
    dv0_d.sat_q.rem = {1'b0, prep_q.delta[7:1]};
    dv0_d.sat_q.dq  = {prep_q.delta[0], 15'd0};
    dv0_d.delta     = prep_q.delta;
    dv0_d.den       = prep_q.den;
    dv0_d.sum       = prep_q.sum;
    dv0_d.sector    = prep_q.sector;
    dv0_d.neg       = prep_q.neg;
    dv0_d.grey      = prep_q.grey;
    dv0_d.sat_zero  = prep_q.sat_zero;
  end

  always_ff @(posedge clk_i) begin
    if (advance) dv_q[0] <= dv0_d;
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    always_comb begin
      dv_n[k]       = dv_q[k];
      dv_n[k].hue_q = rhc_div_step(dv_q[k].hue_q, dv_q[k].delta);
      dv_n[k].sat_q = rhc_div_step(dv_q[k].sat_q, dv_q[k].den);
    end

    always_ff @(posedge clk_i) begin
      if (advance) dv_q[k+1] <= dv_n[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prep_v_q <= 1'b0;
      dv_v_q   <= '0;
      out_v_q  <= 1'b0;
    end else if (advance) begin
      prep_v_q <= pix_i.valid;
      dv_v_q   <= {dv_v_q[DIV_STEPS-1:0], prep_v_q};
      out_v_q  <= dv_v_q[DIV_STEPS];
    end
  end

  // Add the sector base, wrap negative hue into range, zero hue for grey and saturation for a zero denominator
  always_comb begin
    last = dv_q[DIV_STEPS];
    case (last.sector)
      SEC_RED:   hue_s = 16'd0;
      SEC_GREEN: hue_s = HUE_GREEN_BASE;
      SEC_BLUE:  hue_s = HUE_BLUE_BASE;
      default:   hue_s = 16'd0;
    endcase
    hue_w = last.neg ? (hue_s - last.hue_q.dq) : (hue_s + last.hue_q.dq);
    if (hue_w[15]) hue_w = hue_w + HUE_FULL;
    hue_d = last.grey ? 15'd0 : hue_w[14:0];
    sat_d = last.sat_zero ? 16'd0 : last.sat_q.dq;
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      hue_q   <= hue_d;
      sat_q   <= sat_d;
      light_q <= last.sum;
    end
  end

  assign hsl_o.valid      = out_v_q;
  assign hsl_o.hue        = hue_q;
  assign hsl_o.saturation = sat_q;
  assign hsl_o.lightness  = light_q;

endmodule

`default_nettype wire

[hw/rtl/rhc_checker.sv]
// Port-level checks for the RGB to HSL converter and their bind to the top level.
`default_nettype none

module rhc_checker
  import rhc_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        pix_ready_i,
  input wire logic        hsl_valid_i,
  input wire logic        hsl_ready_i,
  input wire logic [14:0] hsl_hue_i,
  input wire logic [15:0] hsl_saturation_i,
  input wire logic [8:0]  hsl_lightness_i
);

  // A waiting result holds until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hsl_valid_i && !hsl_ready_i |=> hsl_valid_i && $stable(hsl_hue_i)
      && $stable(hsl_saturation_i) && $stable(hsl_lightness_i))
    else $error("result changed while stalled");

  // A stalled output freezes the pipeline, so no item may enter
  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hsl_valid_i && !hsl_ready_i |-> !pix_ready_i)
    else $error("item accepted while output stalled");

  a_ranges: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hsl_valid_i |-> hsl_hue_i <= HUE_MAX && hsl_saturation_i <= SAT_ONE
      && hsl_lightness_i <= LIGHT_FULL)
    else $error("result field out of range");

  // Black and white pixels carry no hue and no saturation
  a_black_white: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hsl_valid_i && (hsl_lightness_i == 9'd0 || hsl_lightness_i == LIGHT_FULL)
      |-> hsl_hue_i == 15'd0 && hsl_saturation_i == 16'd0)
    else $error("black or white pixel with hue or saturation");

endmodule

bind rgb_to_hsl_convert_core rhc_checker u_rhc_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .pix_ready_i      (pix_i.ready),
  .hsl_valid_i      (hsl_o.valid),
  .hsl_ready_i      (hsl_o.ready),
  .hsl_hue_i        (hsl_o.hue),
  .hsl_saturation_i (hsl_o.saturation),
  .hsl_lightness_i  (hsl_o.lightness)
);

`default_nettype wire

[verif/testbench.sv]
// Self-checking testbench for the pipelined RGB to HSL converter.
`default_nettype none

module testbench;
  import rhc_pkg::*;

  localparam int SIXTH      = int'(HUE_SIXTH);
  localparam int GREEN_BASE = int'(HUE_GREEN_BASE);
  localparam int BLUE_BASE  = int'(HUE_BLUE_BASE);
  localparam int FULL_TURN  = int'(HUE_FULL);
  localparam int SAT_FULL   = int'(SAT_ONE);
  localparam int LIGHT_TOP  = int'(LIGHT_FULL);

  localparam int unsigned RANDOM_PIXELS = 1800;
  localparam int unsigned QUIET_LIMIT   = 2000;
  localparam int unsigned DRAIN_CYCLES  = 40;
  localparam int unsigned NUM_DIRECTED  = 23;

  typedef struct packed {
    logic [14:0] hue;
    logic [15:0] sat;
    logic [8:0]  light;
  } hsl_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    hsl_t       hsl;
  } pixel_result_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       known;
    hsl_t       hsl;
  } pixel_case_t;

  logic clk;
  logic rst_n;
  bit   steady;
  int   err_count;

  pixel_result_t pending_hsl[$];

  rhc_pixel_if pix ();
  rhc_hsl_if   hsl ();

  rgb_to_hsl_convert_core dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .pix_i  (pix),
    .hsl_o  (hsl)
  );

  // Typed results only where they follow at a glance; rows with known clear use the predictor.
  pixel_case_t directed_cases [NUM_DIRECTED] = '{
    '{8'd0,   8'd0,   8'd0,   1'b1, '{15'd0,     16'd0,     9'd0}},
    '{8'd255, 8'd255, 8'd255, 1'b1, '{15'd0,     16'd0,     9'd510}},
    '{8'd128, 8'd128, 8'd128, 1'b1, '{15'd0,     16'd0,     9'd256}},
    '{8'd255, 8'd0,   8'd0,   1'b1, '{15'd0,     16'd32768, 9'd255}},
    '{8'd0,   8'd255, 8'd0,   1'b1, '{15'd7680,  16'd32768, 9'd255}},
    '{8'd0,   8'd0,   8'd255, 1'b1, '{15'd15360, 16'd32768, 9'd255}},
    '{8'd255, 8'd255, 8'd0,   1'b1, '{15'd3840,  16'd32768, 9'd255}},
    '{8'd0,   8'd255, 8'd255, 1'b1, '{15'd11520, 16'd32768, 9'd255}},
    '{8'd255, 8'd0,   8'd255, 1'b1, '{15'd19200, 16'd32768, 9'd255}},
    '{8'd255, 8'd0,   8'd1,   1'b0, '0},
    '{8'd1,   8'd0,   8'd0,   1'b0, '0},
    '{8'd255, 8'd255, 8'd254, 1'b0, '0},
    '{8'd0,   8'd0,   8'd1,   1'b0, '0},
    '{8'd254, 8'd255, 8'd255, 1'b0, '0},
    '{8'd170, 8'd85,  8'd170, 1'b0, '0},
    '{8'd85,  8'd170, 8'd85,  1'b0, '0},
    '{8'd200, 8'd200, 8'd100, 1'b0, '0},
    '{8'd100, 8'd200, 8'd200, 1'b0, '0},
    '{8'd200, 8'd100, 8'd200, 1'b0, '0},
    '{8'd1,   8'd1,   8'd1,   1'b0, '0},
    '{8'd254, 8'd254, 8'd254, 1'b0, '0},
    '{8'd128, 8'd127, 8'd129, 1'b0, '0},
    '{8'd255, 8'd128, 8'd0,   1'b0, '0}
  };

  function automatic hsl_t hsl_of_pixel(input logic [7:0] r, input logic [7:0] g,
                                        input logic [7:0] b);
    int   red, grn, blu, top, bot, span, total, shade, den;
    hsl_t res;
    red = int'(r);
    grn = int'(g);
    blu = int'(b);
    top = (red > grn) ? red : grn;
    bot = (red < grn) ? red : grn;
    if (blu > top) top = blu;
    if (blu < bot) bot = blu;
    span  = top - bot;
    total = top + bot;
    shade = 0;
    if (span != 0) begin
      // the first channel that reaches the maximum picks the sector
      if (red == top) begin
        shade = (SIXTH * (grn - blu)) / span;
      end else if (grn == top) begin
        shade = GREEN_BASE + (SIXTH * (blu - red)) / span;
      end else begin
        shade = BLUE_BASE + (SIXTH * (red - grn)) / span;
      end
      if (shade < 0) shade += FULL_TURN;
    end
    res.sat = '0;
    if (top != 0 && bot != 255) begin
      den = (total < LIGHT_TOP - total) ? total : LIGHT_TOP - total;
      if (den > 0) res.sat = 16'((span * SAT_FULL) / den);
    end
    res.hue   = 15'(shade);
    res.light = 9'(total);
    return res;
  endfunction

  // Mostly no gap, some short, a few long.
  function automatic int unsigned idle_len();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 88) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                            input bit known, input hsl_t typed_hsl);
    int unsigned   gap;
    pixel_result_t entry;
    gap = steady ? 0 : idle_len();
    if (gap > 0) begin
      pix.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix.valid <= 1'b1;
    pix.red   <= r;
    pix.green <= g;
    pix.blue  <= b;
    do @(posedge clk); while (!pix.ready);
    entry.red   = r;
    entry.green = g;
    entry.blue  = b;
    entry.hsl   = known ? typed_hsl : hsl_of_pixel(r, g, b);
    pending_hsl.push_back(entry);
  endtask

  task automatic report_field(input string field, input int want, input int got,
                              input pixel_result_t entry);
    if (want != got) begin
      $display("%0t: %s mismatch for rgb (%0d,%0d,%0d): expected %0d, actual %0d", $time,
               field, entry.red, entry.green, entry.blue, want, got);
      err_count++;
    end
  endtask

  function automatic logic [7:0] pick_channel();
    case ($urandom_range(0, 4))
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'd1;
      3: return 8'd254;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin : pixel_source
    int unsigned idx;
    int unsigned mode;
    logic [7:0]  r, g, b, v;
    err_count = 0;
    steady    = 1'b0;
    rst_n     = 1'b0;
    pix.valid = 1'b0;
    pix.red   = '0;
    pix.green = '0;
    pix.blue  = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_cases[i]) begin
      send_pixel(directed_cases[i].red, directed_cases[i].green, directed_cases[i].blue,
                 directed_cases[i].known, directed_cases[i].hsl);
    end

    for (idx = 0; idx < RANDOM_PIXELS; idx++) begin
      // hold a stretch at full rate on both sides
      steady = (idx >= 700 && idx < 900);
      mode = $urandom_range(0, 99);
      r = 8'($urandom_range(0, 255));
      g = 8'($urandom_range(0, 255));
      b = 8'($urandom_range(0, 255));
      if (mode >= 60 && mode < 70) begin
        g = r;
        b = r;
      end else if (mode >= 70 && mode < 85) begin
        r = pick_channel();
        g = pick_channel();
        b = pick_channel();
      end else if (mode >= 85) begin
        // two channels tie, which exercises the sector priority
        v = 8'($urandom_range(0, 255));
        case ($urandom_range(0, 2))
          0: begin r = v; g = v; end
          1: begin g = v; b = v; end
          default: begin r = v; b = v; end
        endcase
      end
      send_pixel(r, g, b, 1'b0, '0);
    end
    steady = 1'b0;
    pix.valid <= 1'b0;

    while (pending_hsl.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  initial begin : hsl_sink
    int unsigned   hold;
    pixel_result_t entry;
    hold      = 0;
    hsl.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && hsl.valid && hsl.ready) begin
        if (pending_hsl.size() == 0) begin
          $display("%0t: result with no pixel pending: hue %0d sat %0d light %0d", $time,
                   hsl.hue, hsl.saturation, hsl.lightness);
          err_count++;
        end else begin
          entry = pending_hsl.pop_front();
          report_field("hue", int'(entry.hsl.hue), int'(hsl.hue), entry);
          report_field("saturation", int'(entry.hsl.sat), int'(hsl.saturation), entry);
          report_field("lightness", int'(entry.hsl.light), int'(hsl.lightness), entry);
        end
      end
      if (steady) begin
        hold = 0;
        hsl.ready <= 1'b1;
      end else if (hold > 0) begin
        hold--;
        hsl.ready <= 1'b0;
      end else begin
        hsl.ready <= 1'b1;
        if ($urandom_range(0, 99) < 30) hold = idle_len();
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if (!rst_n || (pix.valid && pix.ready) || (hsl.valid && hsl.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= QUIET_LIMIT) begin
        $display("%0t: no item moved for %0d cycles", $time, quiet);
        $display("testbench: errors");
        $finish;
      end
    end
  end

endmodule

`default_nettype wire

[filelist.f]
hw/rtl/rhc_pkg.sv
hw/rtl/rhc_if.sv
hw/rtl/rgb_to_hsl_convert_core.sv
hw/rtl/rhc_checker.sv
verif/testbench.sv
